@@ rtl/lfu_pkg.sv @@
package lfu_pkg;

    // Fixed field widths of the stream and configuration ports
    localparam int unsigned ENTRY_KEY_W   = 16;
    localparam int unsigned SLOT_INDEX_W  = 4;
    localparam int unsigned EVICTED_KEY_W = 16;
    localparam int unsigned USE_COUNT_W   = 16;
    localparam int unsigned IN_DATA_W     = 16;
    localparam int unsigned OUT_DATA_W    = 40;
    localparam int unsigned CFG_W         = 5;

    // Reset value of the frames-in-use register
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 5'd16;

    // Bit positions of the result fields inside m_tdata
    localparam int unsigned OUT_HIT_LSB   = 0;
    localparam int unsigned OUT_SLOT_LSB  = 1;
    localparam int unsigned OUT_EVV_LSB   = 5;
    localparam int unsigned OUT_EVKEY_LSB = 6;
    localparam int unsigned OUT_COUNT_LSB = 22;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } lfu_state_t;

    // Flags of the search token that walks down the cell row
    typedef struct packed {
        logic valid;
        logic hit;
        logic have_cand;
        logic have_free;
    } tok_ctl_t;

    // Flags of the update broadcast to every cell
    typedef struct packed {
        logic en;
        logic hit;
        logic evict;
    } upd_ctl_t;

endpackage

@@ rtl/lfu_cell.sv @@
module lfu_cell #(
    parameter int unsigned SLOT_W      = 4,
    parameter int unsigned KEY_WIDTH   = 16,
    parameter int unsigned COUNT_WIDTH = 16,
    parameter int unsigned CELL_IDX    = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Search token from the left neighbor
    input  lfu_pkg::tok_ctl_t      tok_ctl_in,
    input  logic [KEY_WIDTH-1:0]   tok_key_in,
    input  logic [SLOT_W-1:0]      tok_hit_slot_in,
    input  logic [COUNT_WIDTH-1:0] tok_hit_cnt_in,
    input  logic [COUNT_WIDTH-1:0] tok_cand_cnt_in,
    input  logic [SLOT_W-1:0]      tok_cand_rank_in,
    input  logic [SLOT_W-1:0]      tok_cand_slot_in,
    input  logic [KEY_WIDTH-1:0]   tok_cand_key_in,
    input  logic [SLOT_W-1:0]      tok_free_slot_in,
    // Search token to the right neighbor
    output lfu_pkg::tok_ctl_t      tok_ctl_out,
    output logic [KEY_WIDTH-1:0]   tok_key_out,
    output logic [SLOT_W-1:0]      tok_hit_slot_out,
    output logic [COUNT_WIDTH-1:0] tok_hit_cnt_out,
    output logic [COUNT_WIDTH-1:0] tok_cand_cnt_out,
    output logic [SLOT_W-1:0]      tok_cand_rank_out,
    output logic [SLOT_W-1:0]      tok_cand_slot_out,
    output logic [KEY_WIDTH-1:0]   tok_cand_key_out,
    output logic [SLOT_W-1:0]      tok_free_slot_out,
    // Update broadcast
    input  lfu_pkg::upd_ctl_t      upd_ctl,
    input  logic [SLOT_W-1:0]      upd_slot,
    input  logic [SLOT_W-1:0]      upd_vrank,
    input  logic [SLOT_W-1:0]      upd_new_rank,
    input  logic [KEY_WIDTH-1:0]   upd_key
);
    import lfu_pkg::*;

    localparam logic [SLOT_W-1:0]      MY_SLOT   = SLOT_W'(CELL_IDX);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Slot contents
    logic                   valid_reg, valid_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [SLOT_W-1:0]      rank_reg, rank_next;

    // Token stage
    tok_ctl_t               tctl_reg, tctl_next;
    logic [KEY_WIDTH-1:0]   tkey_reg, tkey_next;
    logic [SLOT_W-1:0]      thslot_reg, thslot_next;
    logic [COUNT_WIDTH-1:0] thcnt_reg, thcnt_next;
    logic [COUNT_WIDTH-1:0] tccnt_reg, tccnt_next;
    logic [SLOT_W-1:0]      tcrank_reg, tcrank_next;
    logic [SLOT_W-1:0]      tcslot_reg, tcslot_next;
    logic [KEY_WIDTH-1:0]   tckey_reg, tckey_next;
    logic [SLOT_W-1:0]      tfree_reg, tfree_next;

    logic                   better;

    // This slot beats the candidate carried so far: lower count, or same count and older
    assign better = valid_reg && (!tok_ctl_in.have_cand || (count_reg < tok_cand_cnt_in) ||
                    ((count_reg == tok_cand_cnt_in) && (rank_reg < tok_cand_rank_in)));

    // Fold this slot into the passing token
    always_comb begin
        tctl_next   = tok_ctl_in;
        tkey_next   = tok_key_in;
        thslot_next = tok_hit_slot_in;
        thcnt_next  = tok_hit_cnt_in;
        tccnt_next  = tok_cand_cnt_in;
        tcrank_next = tok_cand_rank_in;
        tcslot_next = tok_cand_slot_in;
        tckey_next  = tok_cand_key_in;
        tfree_next  = tok_free_slot_in;
        if (tok_ctl_in.valid) begin
            if (valid_reg && !tok_ctl_in.hit && (key_reg == tok_key_in)) begin
                tctl_next.hit = 1'b1;
                thslot_next   = MY_SLOT;
                thcnt_next    = count_reg;
            end
            if (better) begin
                tctl_next.have_cand = 1'b1;
                tccnt_next          = count_reg;
                tcrank_next         = rank_reg;
                tcslot_next         = MY_SLOT;
                tckey_next          = key_reg;
            end
            if (!valid_reg && !tok_ctl_in.have_free) begin
                tctl_next.have_free = 1'b1;
                tfree_next          = MY_SLOT;
            end
        end
    end

    // Apply the committed access to this slot
    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        rank_next  = rank_reg;
        if (upd_ctl.en) begin
            if (upd_ctl.hit) begin
                if ((upd_slot == MY_SLOT) && (count_reg != COUNT_MAX)) begin
                    count_next = count_reg + COUNT_WIDTH'(1);
                end
            end else begin
                // Entries younger than the victim move one rank toward the oldest
                if (upd_ctl.evict && valid_reg && (rank_reg > upd_vrank)) begin
                    rank_next = rank_reg - SLOT_W'(1);
                end
                if (upd_slot == MY_SLOT) begin
                    valid_next = 1'b1;
                    key_next   = upd_key;
                    count_next = COUNT_WIDTH'(1);
                    rank_next  = upd_new_rank;
                end
            end
        end
    end

    // Control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tctl_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            tctl_reg  <= tctl_next;
        end
    end

    // Payload flops
    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        count_reg  <= count_next;
        rank_reg   <= rank_next;
        tkey_reg   <= tkey_next;
        thslot_reg <= thslot_next;
        thcnt_reg  <= thcnt_next;
        tccnt_reg  <= tccnt_next;
        tcrank_reg <= tcrank_next;
        tcslot_reg <= tcslot_next;
        tckey_reg  <= tckey_next;
        tfree_reg  <= tfree_next;
    end

    assign tok_ctl_out       = tctl_reg;
    assign tok_key_out       = tkey_reg;
    assign tok_hit_slot_out  = thslot_reg;
    assign tok_hit_cnt_out   = thcnt_reg;
    assign tok_cand_cnt_out  = tccnt_reg;
    assign tok_cand_rank_out = tcrank_reg;
    assign tok_cand_slot_out = tcslot_reg;
    assign tok_cand_key_out  = tckey_reg;
    assign tok_free_slot_out = tfree_reg;

endmodule

@@ rtl/lfu_replacement_table.sv @@
// Least-frequently-used replacement table with oldest-first tie break. Each beat on the
// s_ side carries one access key; each beat on the m_ side reports whether it hit, the slot
// that now holds it, the key evicted to make room (if any) and its use count after the
// access. Counts saturate at all ones. One access is handled at a time: a search token
// passes through the row of FRAMES slot cells one cell per clock, starting at the accepting
// edge, collecting the hit, the eviction candidate and the first free slot; the search
// outcome is then registered, and the commit state applies the update to all cells at once.
// The next access can be accepted in the cycle in which the result appears, even if that
// beat is not yet taken; the commit waits only while an earlier result is still held.
// frames_in_use may be written only while no access is in flight; 0 acts as 1 and values
// above FRAMES act as FRAMES.
module lfu_replacement_table #(
    parameter int unsigned FRAMES      = 16,
    parameter int unsigned KEY_WIDTH   = 16,
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration
    input  logic                             cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]        cfg_wdata,   // frames_in_use
    // Access stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lfu_pkg::IN_DATA_W-1:0]    s_tdata,     // [15:0] entry_key
    // Result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] was_hit, [4:1] slot_index, [5] evicted_valid, [21:6] evicted_key,
    // [37:22] use_count, [39:38] zero
    output logic [lfu_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import lfu_pkg::*;

    localparam int unsigned SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int unsigned OCC_W  = $clog2(FRAMES + 1);
    localparam int unsigned LIM_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Token chain between the cells; element 0 is the launch point
    tok_ctl_t               c_ctl   [FRAMES+1];
    logic [KEY_WIDTH-1:0]   c_key   [FRAMES+1];
    logic [SLOT_W-1:0]      c_hslot [FRAMES+1];
    logic [COUNT_WIDTH-1:0] c_hcnt  [FRAMES+1];
    logic [COUNT_WIDTH-1:0] c_ccnt  [FRAMES+1];
    logic [SLOT_W-1:0]      c_crank [FRAMES+1];
    logic [SLOT_W-1:0]      c_cslot [FRAMES+1];
    logic [KEY_WIDTH-1:0]   c_ckey  [FRAMES+1];
    logic [SLOT_W-1:0]      c_free  [FRAMES+1];

    lfu_state_t             state_reg, state_next;
    logic [CFG_W-1:0]       frames_in_use_reg;
    logic [OCC_W-1:0]       occ_reg, occ_next;

    // Search result held until commit
    logic                   h_hit_reg;
    logic [KEY_WIDTH-1:0]   h_key_reg;
    logic [SLOT_W-1:0]      h_hslot_reg;
    logic [COUNT_WIDTH-1:0] h_hcnt_reg;
    logic [SLOT_W-1:0]      h_cslot_reg;
    logic [SLOT_W-1:0]      h_crank_reg;
    logic [KEY_WIDTH-1:0]   h_ckey_reg;
    logic [SLOT_W-1:0]      h_free_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;

    logic                   accept;
    logic                   out_free;
    logic                   capture;
    logic [LIM_W-1:0]       cfg_ext;
    logic [LIM_W-1:0]       limit;
    logic                   full;
    upd_ctl_t               upd_ctl;
    logic [SLOT_W-1:0]      upd_slot;
    logic [SLOT_W-1:0]      upd_new_rank;
    logic [COUNT_WIDTH-1:0] use_cnt;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign capture  = (state_reg == ST_SCAN) && c_ctl[FRAMES].valid;

    // Launch a fresh token into the first cell
    always_comb begin
        c_ctl[0]       = '0;
        c_ctl[0].valid = accept;
        c_key[0]       = KEY_WIDTH'(s_tdata[ENTRY_KEY_W-1:0]);
        c_hslot[0]     = '0;
        c_hcnt[0]      = '0;
        c_ccnt[0]      = '0;
        c_crank[0]     = '0;
        c_cslot[0]     = '0;
        c_ckey[0]      = '0;
        c_free[0]      = '0;
    end

    // Row of slot cells
    for (genvar i = 0; i < FRAMES; i++) begin : g_cell
        lfu_cell #(
            .SLOT_W      (SLOT_W),
            .KEY_WIDTH   (KEY_WIDTH),
            .COUNT_WIDTH (COUNT_WIDTH),
            .CELL_IDX    (i)
        ) u_cell (
            .aclk              (aclk),
            .aresetn           (aresetn),
            .tok_ctl_in        (c_ctl[i]),
            .tok_key_in        (c_key[i]),
            .tok_hit_slot_in   (c_hslot[i]),
            .tok_hit_cnt_in    (c_hcnt[i]),
            .tok_cand_cnt_in   (c_ccnt[i]),
            .tok_cand_rank_in  (c_crank[i]),
            .tok_cand_slot_in  (c_cslot[i]),
            .tok_cand_key_in   (c_ckey[i]),
            .tok_free_slot_in  (c_free[i]),
            .tok_ctl_out       (c_ctl[i+1]),
            .tok_key_out       (c_key[i+1]),
            .tok_hit_slot_out  (c_hslot[i+1]),
            .tok_hit_cnt_out   (c_hcnt[i+1]),
            .tok_cand_cnt_out  (c_ccnt[i+1]),
            .tok_cand_rank_out (c_crank[i+1]),
            .tok_cand_slot_out (c_cslot[i+1]),
            .tok_cand_key_out  (c_ckey[i+1]),
            .tok_free_slot_out (c_free[i+1]),
            .upd_ctl           (upd_ctl),
            .upd_slot          (upd_slot),
            .upd_vrank         (h_crank_reg),
            .upd_new_rank      (upd_new_rank),
            .upd_key           (h_key_reg)
        );
    end

    // Effective table size
    assign cfg_ext = LIM_W'(frames_in_use_reg);
    always_comb begin
        limit = cfg_ext;
        if (cfg_ext == '0) begin
            limit = LIM_W'(1);
        end else if (cfg_ext > LIM_W'(FRAMES)) begin
            limit = LIM_W'(FRAMES);
        end
    end
    assign full = (LIM_W'(occ_reg) >= limit);

    // Sequencer, commit decision and result formatting
    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        upd_ctl      = '0;
        upd_slot     = h_free_reg;
        upd_new_rank = SLOT_W'(occ_reg);
        use_cnt      = COUNT_WIDTH'(1);

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (h_hit_reg) begin
            upd_slot = h_hslot_reg;
            use_cnt  = (h_hcnt_reg == COUNT_MAX) ? COUNT_MAX : h_hcnt_reg + COUNT_WIDTH'(1);
        end else if (full) begin
            upd_slot     = h_cslot_reg;
            upd_new_rank = SLOT_W'(occ_reg - OCC_W'(1));
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (capture) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    upd_ctl.en    = 1'b1;
                    upd_ctl.hit   = h_hit_reg;
                    upd_ctl.evict = !h_hit_reg && full;
                    if (!h_hit_reg && !full) begin
                        occ_next = occ_reg + OCC_W'(1);
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[OUT_HIT_LSB] = h_hit_reg;
                    m_data_next[OUT_SLOT_LSB +: SLOT_INDEX_W] = SLOT_INDEX_W'(upd_slot);
                    m_data_next[OUT_EVV_LSB] = upd_ctl.evict;
                    m_data_next[OUT_EVKEY_LSB +: EVICTED_KEY_W] =
                        upd_ctl.evict ? EVICTED_KEY_W'(h_ckey_reg) : '0;
                    m_data_next[OUT_COUNT_LSB +: USE_COUNT_W] = USE_COUNT_W'(use_cnt);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            occ_reg           <= '0;
            m_valid_reg       <= 1'b0;
            frames_in_use_reg <= FRAMES_IN_USE_RST;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                frames_in_use_reg <= cfg_wdata;
            end
        end
    end

    // Search result capture and output data; the key leaves the row with the token
    always_ff @(posedge aclk) begin
        if (capture) begin
            h_hit_reg   <= c_ctl[FRAMES].hit;
            h_key_reg   <= c_key[FRAMES];
            h_hslot_reg <= c_hslot[FRAMES];
            h_hcnt_reg  <= c_hcnt[FRAMES];
            h_cslot_reg <= c_cslot[FRAMES];
            h_crank_reg <= c_crank[FRAMES];
            h_ckey_reg  <= c_ckey[FRAMES];
            h_free_reg  <= c_free[FRAMES];
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/lfu_chk.sv @@
module lfu_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lfu_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lfu_pkg::*;

    // A stalled result beat holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One access at a time: no new beat is taken right after one was accepted
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second access accepted during a search");

    // A new result only appears at the end of a search
    a_result_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a search in flight");

    // A hit never evicts, and a miss always reports a count of one
    a_hit_miss_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_HIT_LSB] ?
            (!m_tdata[OUT_EVV_LSB] && (m_tdata[OUT_EVKEY_LSB +: EVICTED_KEY_W] == '0)) :
            (m_tdata[OUT_COUNT_LSB +: USE_COUNT_W] == USE_COUNT_W'(1))))
        else $error("inconsistent hit, eviction or count fields");

endmodule

bind lfu_replacement_table lfu_chk u_lfu_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/lfu_table_checker.sv @@
// Watches the access and result streams of the LFU replacement table, keeps its own
// copy of the slot table, and compares every result beat with the oldest prediction.
module lfu_table_checker #(
    parameter int unsigned FRAMES = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lfu_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [lfu_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [lfu_pkg::OUT_DATA_W-1:0]   m_tdata,
    output int unsigned                      fail_count,
    output int unsigned                      outstanding
);
    import lfu_pkg::*;

    localparam int unsigned REPORT_MAX = 10;
    localparam logic [USE_COUNT_W-1:0] COUNT_MAX = '1;
    localparam int unsigned PAD_LSB = OUT_COUNT_LSB + USE_COUNT_W;

    typedef struct packed {
        logic                      hit;
        logic [SLOT_INDEX_W-1:0]   slot;
        logic                      evicted;
        logic [EVICTED_KEY_W-1:0]  evicted_key;
        logic [USE_COUNT_W-1:0]    count;
    } access_result_t;

    // Shadow copy of the slot table
    logic                   slot_used [FRAMES];
    logic [ENTRY_KEY_W-1:0] slot_id   [FRAMES];
    logic [USE_COUNT_W-1:0] slot_uses [FRAMES];
    int unsigned            slot_age  [FRAMES];
    int unsigned            fill_level;
    logic [CFG_W-1:0]       frames_reg;

    access_result_t         expected_q[$];
    access_result_t         want;
    access_result_t         got;
    int unsigned            mismatches;
    int unsigned            result_no;
    int unsigned            clr;

    // Apply one access to the shadow table and return the result it should produce.
    function automatic access_result_t predict_access(input logic [ENTRY_KEY_W-1:0] key);
        access_result_t res;
        int unsigned    limit;
        int unsigned    pick;
        int unsigned    old_age;
        int unsigned    new_age;
        int unsigned    s;
        bit             found;
        bit             have;
        res   = '0;
        pick  = 0;
        found = 1'b0;
        have  = 1'b0;
        limit = (frames_reg == 0) ? 1 : ((frames_reg > FRAMES) ? FRAMES : frames_reg);
        for (s = 0; s < FRAMES; s++) begin
            if (!found && slot_used[s] && slot_id[s] == key) begin
                pick  = s;
                found = 1'b1;
            end
        end
        if (found) begin
            res.hit = 1'b1;
            if (slot_uses[pick] != COUNT_MAX) begin
                slot_uses[pick] = slot_uses[pick] + 1'b1;
            end
        end else begin
            if (fill_level >= limit) begin
                // Full table: lowest count loses, the oldest entry among equal counts.
                for (s = 0; s < FRAMES; s++) begin
                    if (slot_used[s] && (!have || slot_uses[s] < slot_uses[pick] ||
                        (slot_uses[s] == slot_uses[pick] && slot_age[s] < slot_age[pick]))) begin
                        pick = s;
                        have = 1'b1;
                    end
                end
                old_age = slot_age[pick];
                res.evicted     = 1'b1;
                res.evicted_key = slot_id[pick];
                for (s = 0; s < FRAMES; s++) begin
                    if (slot_used[s] && slot_age[s] > old_age) begin
                        slot_age[s] = slot_age[s] - 1;
                    end
                end
                new_age = fill_level - 1;
            end else begin
                // Room left: take the lowest-numbered free slot.
                for (s = 0; s < FRAMES; s++) begin
                    if (!have && !slot_used[s]) begin
                        pick = s;
                        have = 1'b1;
                    end
                end
                new_age    = fill_level;
                fill_level = fill_level + 1;
            end
            slot_used[pick] = 1'b1;
            slot_id[pick]   = key;
            slot_uses[pick] = USE_COUNT_W'(1);
            slot_age[pick]  = new_age;
        end
        res.slot  = pick[SLOT_INDEX_W-1:0];
        res.count = slot_uses[pick];
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (mismatches < REPORT_MAX) begin
            $display("mismatch in %s at result %0d: expected %0h, got %0h",
                     what, result_no, want_v, got_v);
        end
        mismatches++;
    endtask

    // Sample both streams at the clock edge; results are checked before new accesses queue.
    always @(posedge aclk) begin
        if (!aresetn) begin
            for (clr = 0; clr < FRAMES; clr++) begin
                slot_used[clr] = 1'b0;
            end
            fill_level = 0;
            frames_reg = FRAMES_IN_USE_RST;
            expected_q.delete();
            mismatches = 0;
            result_no  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.hit         = m_tdata[OUT_HIT_LSB];
                got.slot        = m_tdata[OUT_SLOT_LSB +: SLOT_INDEX_W];
                got.evicted     = m_tdata[OUT_EVV_LSB];
                got.evicted_key = m_tdata[OUT_EVKEY_LSB +: EVICTED_KEY_W];
                got.count       = m_tdata[OUT_COUNT_LSB +: USE_COUNT_W];
                if (expected_q.size() == 0) begin
                    note_mismatch("result beat with no access waiting", 0, m_tdata[31:0]);
                end else begin
                    want = expected_q.pop_front();
                    if (got.hit !== want.hit)
                        note_mismatch("was_hit", 32'(want.hit), 32'(got.hit));
                    if (got.slot !== want.slot)
                        note_mismatch("slot_index", 32'(want.slot), 32'(got.slot));
                    if (got.evicted !== want.evicted)
                        note_mismatch("evicted_valid", 32'(want.evicted), 32'(got.evicted));
                    if (got.evicted_key !== want.evicted_key)
                        note_mismatch("evicted_key", 32'(want.evicted_key),
                                      32'(got.evicted_key));
                    if (got.count !== want.count)
                        note_mismatch("use_count", 32'(want.count), 32'(got.count));
                    if (m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0)
                        note_mismatch("tdata padding", 0,
                                      32'(m_tdata[OUT_DATA_W-1:PAD_LSB]));
                end
                result_no++;
            end
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_access(s_tdata[ENTRY_KEY_W-1:0]));
            end
            if (cfg_we) begin
                frames_reg = cfg_wdata;
            end
        end
        fail_count  <= mismatches;
        outstanding <= expected_q.size();
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import lfu_pkg::*;

    localparam int unsigned FRAMES       = 16;
    localparam int unsigned RUN_LIMIT    = 200_000;
    localparam int unsigned TAIL_CYCLES  = FRAMES + 8;
    localparam int unsigned RANDOM_ITEMS = 850;
    localparam int unsigned POOL_SIZE    = 24;
    localparam int unsigned MAX_GAP      = 6;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata = '0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]   m_tdata;

    int unsigned             fail_count;
    int unsigned             outstanding;

    bit                      send_calm = 1'b0;
    bit                      recv_calm = 1'b0;
    int unsigned             ready_wait;
    int unsigned             hold_draw;
    logic [ENTRY_KEY_W-1:0]  key_pool [POOL_SIZE];

    lfu_replacement_table #(
        .FRAMES      (FRAMES),
        .KEY_WIDTH   (ENTRY_KEY_W),
        .COUNT_WIDTH (USE_COUNT_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    lfu_table_checker #(
        .FRAMES (FRAMES)
    ) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 aclk = ~aclk;

    // Result side: after a beat, ready may drop for a random gap; in calm phases it stays high.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_wait <= 0;
        end else if (m_tready && m_tvalid) begin
            hold_draw = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_draw != 0) begin
                m_tready   <= 1'b0;
                ready_wait <= hold_draw - 1;
            end
        end else if (!m_tready) begin
            if (ready_wait == 0) begin
                m_tready <= 1'b1;
            end else begin
                ready_wait <= ready_wait - 1;
            end
        end
    end

    // Offer one access key after a random gap and wait until the block takes it.
    task automatic send_key(input logic [ENTRY_KEY_W-1:0] key);
        int unsigned gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Stop offering accesses and wait until every predicted result has been seen.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly keys from a small pool, skewed toward its first entries so counts differ.
    function automatic logic [ENTRY_KEY_W-1:0] pick_key();
        int unsigned idx;
        if ($urandom_range(0, 99) < 15) begin
            return ENTRY_KEY_W'($urandom);
        end
        idx = $urandom_range(0, $urandom_range(0, POOL_SIZE - 1));
        return key_pool[idx];
    endfunction

    function automatic logic [CFG_W-1:0] pick_frames();
        case ($urandom_range(0, 5))
            0: return CFG_W'(0);
            1: return CFG_W'(1);
            2: return CFG_W'(FRAMES);
            3: return '1;
            default: return CFG_W'($urandom_range(0, 31));
        endcase
    endfunction

    // Run limit: any hang ends the run as a failure.
    initial begin
        repeat (RUN_LIMIT) @(posedge aclk);
        $display("lfu_replacement_table regression: fail");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        int unsigned sent;
        int unsigned phase_len;
        int unsigned i;
        for (i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = ENTRY_KEY_W'($urandom);
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero setting behaves as a single slot: every miss after the first replaces it.
        write_frames(CFG_W'(0));
        send_key(16'h0000);
        send_key(16'hFFFF);
        send_key(16'hFFFF);
        send_key(16'h0000);

        // Three slots: ties on count fall to the oldest entry.
        drain_results();
        write_frames(CFG_W'(3));
        send_key(16'h0001);
        send_key(16'h0002);
        send_key(16'h0001);
        send_key(16'h0003);
        send_key(16'h0004);

        // Limit lowered below the current occupancy.
        drain_results();
        write_frames(CFG_W'(1));
        send_key(16'h0005);
        send_key(16'h0005);

        // A setting above the built size behaves as the full table; fill it and evict.
        drain_results();
        write_frames('1);
        for (i = 0; i < 13; i++) begin
            send_key(16'h0008 << i);
        end
        send_key(16'hAAAA);
        send_key(16'h5555);

        // Random phases, each under a fresh setting written while the block is idle.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_results();
            write_frames(pick_frames());
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
            for (i = 0; i < 4; i++) begin
                key_pool[$urandom_range(0, POOL_SIZE - 1)] = ENTRY_KEY_W'($urandom);
            end
            phase_len = $urandom_range(40, 160);
            for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
                send_key(pick_key());
                sent++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("lfu_replacement_table regression: pass");
        end else begin
            $display("lfu_replacement_table regression: fail");
        end
        $finish;
    end

endmodule
